// ===== rtl/tabt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package tabt_pkg;

    localparam int ONSET_DEPTH_DEF = 256;
    localparam int TEMPO_DEPTH_DEF = 8;

    localparam int ONSET_W = 16;
    localparam int NUM_W   = 64;
    localparam int DEN_W   = 40;
    localparam int QUO_CW  = $clog2(NUM_W + 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;
    localparam logic [CFG_IDX_W-1:0] CFG_HOP_SIZE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_TEMPO   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TEMPO   = 2'd3;

    localparam logic [12:0] HOP_RST   = 13'd512;
    localparam logic [17:0] SR_RST    = 18'd44100;
    localparam logic [8:0]  MINT_RST  = 9'd60;
    localparam logic [8:0]  MAXT_RST  = 9'd200;

    localparam logic [20:0] EST_PERIOD_US = 21'd500000;
    localparam logic [29:0] PERIOD_NUM    = 30'd960000000;
    localparam int          CONF_MIN_N    = 4;

    typedef struct packed {
        logic        kind;
        logic [15:0] onset_value;
        logic [19:0] dt_us;
        logic        detected;
    } t_in_req;

    typedef struct packed {
        logic        beat_hit;
        logic        bar_hit;
        logic [15:0] phase_frac;
        logic [15:0] tempo;
        logic [15:0] confidence;
    } t_out_req;

endpackage
`default_nettype wire

// ===== rtl/tabt_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tabt_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_go,
    input  wire logic [tabt_pkg::NUM_W-1:0] i_num,
    input  wire logic [tabt_pkg::DEN_W-1:0] i_den,
    output logic                            o_done,
    output logic [tabt_pkg::NUM_W-1:0]      o_quo
);
    import tabt_pkg::*;

    // restoring divider, one quotient bit per cycle
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [NUM_W-1:0]  r_q;
    logic [QUO_CW-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DEN_W:0]    w_sh;
    logic              w_ge;

    assign w_sh = {r_rem, r_q[NUM_W-1]};
    assign w_ge = w_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_rem  <= '0;
            r_den  <= '0;
            r_q    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_rem  <= '0;
                r_den  <= i_den;
                r_q    <= i_num;
                r_cnt  <= QUO_CW'(NUM_W);
            end else if (r_busy) begin
                r_rem <= w_ge ? DEN_W'(w_sh - {1'b0, r_den}) : w_sh[DEN_W-1:0];
                r_q   <= {r_q[NUM_W-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == QUO_CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule
`default_nettype wire

// ===== rtl/tabt_corr.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tabt_corr #(
    parameter int ONSET_DEPTH = tabt_pkg::ONSET_DEPTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_wr,
    input  wire logic [tabt_pkg::ONSET_W-1:0]   i_wdata,
    input  wire logic                           i_go,
    input  wire logic [$clog2(ONSET_DEPTH)-1:0] i_lo,
    input  wire logic [$clog2(ONSET_DEPTH)-1:0] i_hi,
    output logic                                o_clearing,
    output logic                                o_done,
    output logic [$clog2(ONSET_DEPTH)-1:0]      o_win_lag
);
    import tabt_pkg::*;

    localparam int AW    = $clog2(ONSET_DEPTH);
    localparam int ACC_W = 2 * ONSET_W + AW;
    localparam logic [AW:0] DEPTH_V = (AW+1)'(ONSET_DEPTH);

    localparam logic [1:0] C_IDLE  = 2'd0;
    localparam logic [1:0] C_SETUP = 2'd1;
    localparam logic [1:0] C_RUN   = 2'd2;
    localparam logic [1:0] C_DRAIN = 2'd3;

    logic [ONSET_W-1:0]   r_mem [ONSET_DEPTH];
    logic [ONSET_W-1:0]   r_qa, r_qb;
    logic [2*ONSET_W-1:0] r_prod;
    logic [ACC_W-1:0]     r_acc, r_best;
    logic [AW-1:0]        r_ptr, r_caddr, r_ia, r_ib, r_cnt, r_lag, r_hi, r_blag;
    logic                 r_clr, r_v1, r_v2, r_done;
    logic [1:0]           r_state;

    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    logic [ONSET_W-1:0]   w_wdata;
    logic [AW:0]          w_bsum;

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] a);
        f_inc = (a == AW'(ONSET_DEPTH - 1)) ? '0 : a + 1'b1;
    endfunction

    assign w_we    = r_clr | i_wr;
    assign w_waddr = r_clr ? r_caddr : r_ptr;
    assign w_wdata = r_clr ? '0 : i_wdata;
    assign w_bsum  = {1'b0, r_ptr} + {1'b0, r_lag};

    // history ring: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_qa <= r_mem[r_ia];
        r_qb <= r_mem[r_ib];
    end

    always_ff @(posedge i_clk) begin
        r_prod <= r_qa * r_qb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr   <= 1'b1;
            r_caddr <= '0;
            r_ptr   <= '0;
            r_state <= C_IDLE;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_done  <= 1'b0;
            r_ia    <= '0;
            r_ib    <= '0;
            r_cnt   <= '0;
            r_lag   <= '0;
            r_hi    <= '0;
            r_blag  <= '0;
            r_best  <= '0;
            r_acc   <= '0;
        end else begin
            r_done <= 1'b0;
            r_v1   <= r_state == C_RUN;
            r_v2   <= r_v1;
            if (r_clr) begin
                r_caddr <= f_inc(r_caddr);
                if (r_caddr == AW'(ONSET_DEPTH - 1)) begin
                    r_clr <= 1'b0;
                end
            end
            if (i_wr) begin
                r_ptr <= f_inc(r_ptr);
            end
            if (r_v2) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
            unique case (r_state)
                C_IDLE: begin
                    if (i_go) begin
                        r_lag   <= i_lo;
                        r_hi    <= i_hi;
                        r_best  <= '0;
                        r_blag  <= '0;
                        r_state <= C_SETUP;
                    end
                end
                C_SETUP: begin
                    r_ia    <= r_ptr;
                    r_ib    <= (w_bsum >= DEPTH_V) ? AW'(w_bsum - DEPTH_V) : w_bsum[AW-1:0];
                    r_cnt   <= AW'(DEPTH_V - {1'b0, r_lag});
                    r_acc   <= '0;
                    r_state <= C_RUN;
                end
                C_RUN: begin
                    r_ia  <= f_inc(r_ia);
                    r_ib  <= f_inc(r_ib);
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == AW'(1)) begin
                        r_state <= C_DRAIN;
                    end
                end
                C_DRAIN: begin
                    if (!r_v1 && !r_v2) begin
                        // first strictly larger sum wins
                        if (r_acc > r_best) begin
                            r_best <= r_acc;
                            r_blag <= r_lag;
                        end
                        if (r_lag == r_hi) begin
                            r_done  <= 1'b1;
                            r_state <= C_IDLE;
                        end else begin
                            r_lag   <= r_lag + 1'b1;
                            r_state <= C_SETUP;
                        end
                    end
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

    assign o_clearing = r_clr;
    assign o_done     = r_done;
    assign o_win_lag  = r_blag;

endmodule
`default_nettype wire

// ===== rtl/tabt_tempo.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tabt_tempo #(
    parameter int TEMPO_DEPTH = tabt_pkg::TEMPO_DEPTH_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_go,
    input  wire logic [15:0]                      i_bpm,
    output logic                                  o_done,
    output logic [15:0]                           o_median,
    output logic [tabt_pkg::DEN_W-1:0]            o_ss,
    output logic [$clog2(TEMPO_DEPTH+1)-1:0]      o_count
);
    import tabt_pkg::*;

    localparam int IW = $clog2(TEMPO_DEPTH);
    localparam int CW = $clog2(TEMPO_DEPTH + 1);

    localparam logic [3:0] T_IDLE = 4'd0;
    localparam logic [3:0] T_WR   = 4'd1;
    localparam logic [3:0] T_KRD  = 4'd2;
    localparam logic [3:0] T_KCAP = 4'd3;
    localparam logic [3:0] T_JRD  = 4'd4;
    localparam logic [3:0] T_JUSE = 4'd5;
    localparam logic [3:0] T_DEC  = 4'd6;
    localparam logic [3:0] T_SRD  = 4'd7;
    localparam logic [3:0] T_SMUL = 4'd8;
    localparam logic [3:0] T_SACC = 4'd9;
    localparam logic [3:0] T_DONE = 4'd10;

    logic [15:0]      r_mem [TEMPO_DEPTH];
    logic [15:0]      r_rd, r_bpm, r_cand, r_med;
    logic [IW-1:0]    r_ptr;
    logic [CW-1:0]    r_cnt, r_k, r_j, r_lt, r_le;
    logic [31:0]      r_sq;
    logic [DEN_W-1:0] r_ss;
    logic [3:0]       r_state;

    logic [IW-1:0]        w_ra;
    logic [CW-1:0]        w_half;
    logic signed [16:0]   w_d;
    logic signed [33:0]   w_dsq;

    assign w_ra   = (r_state == T_JRD) ? r_j[IW-1:0] : r_k[IW-1:0];
    assign w_half = r_cnt >> 1;
    assign w_d    = $signed({1'b0, r_rd}) - $signed({1'b0, r_med});
    assign w_dsq  = w_d * w_d;

    always_ff @(posedge i_clk) begin
        if (r_state == T_WR) begin
            r_mem[r_ptr] <= r_bpm;
        end
        r_rd <= r_mem[w_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
            r_ptr   <= '0;
            r_cnt   <= '0;
            r_k     <= '0;
            r_j     <= '0;
            r_lt    <= '0;
            r_le    <= '0;
            r_bpm   <= '0;
            r_cand  <= '0;
            r_med   <= '0;
            r_sq    <= '0;
            r_ss    <= '0;
        end else begin
            unique case (r_state)
                T_IDLE: begin
                    if (i_go) begin
                        r_bpm   <= i_bpm;
                        r_state <= T_WR;
                    end
                end
                T_WR: begin
                    r_ptr <= (r_ptr == IW'(TEMPO_DEPTH - 1)) ? '0 : r_ptr + 1'b1;
                    if (r_cnt != CW'(TEMPO_DEPTH)) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    r_k     <= '0;
                    r_state <= T_KRD;
                end
                T_KRD: r_state <= T_KCAP;
                T_KCAP: begin
                    r_cand  <= r_rd;
                    r_j     <= '0;
                    r_lt    <= '0;
                    r_le    <= '0;
                    r_state <= T_JRD;
                end
                T_JRD: r_state <= T_JUSE;
                T_JUSE: begin
                    if (r_rd < r_cand) begin
                        r_lt <= r_lt + 1'b1;
                    end
                    if (r_rd <= r_cand) begin
                        r_le <= r_le + 1'b1;
                    end
                    if (r_j == r_cnt - 1'b1) begin
                        r_state <= T_DEC;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= T_JRD;
                    end
                end
                T_DEC: begin
                    // candidate covers sorted position count/2
                    if (r_lt <= w_half && w_half < r_le) begin
                        r_med   <= r_cand;
                        r_k     <= '0;
                        r_ss    <= '0;
                        r_state <= T_SRD;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= T_KRD;
                    end
                end
                T_SRD: r_state <= T_SMUL;
                T_SMUL: begin
                    r_sq    <= w_dsq[31:0];
                    r_state <= T_SACC;
                end
                T_SACC: begin
                    r_ss <= r_ss + DEN_W'(r_sq);
                    if (r_k == r_cnt - 1'b1) begin
                        r_state <= T_DONE;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= T_SRD;
                    end
                end
                T_DONE: r_state <= T_IDLE;
                default: r_state <= T_IDLE;
            endcase
        end
    end

    assign o_done   = r_state == T_DONE;
    assign o_median = r_med;
    assign o_ss     = r_ss;
    assign o_count  = r_cnt;

endmodule
`default_nettype wire

// ===== rtl/tempo_autocorr_beat_tracker.sv =====
// Steps from accept to result valid: an onset sample or a tick uses at most one phase
// divide, and none while no tempo exists.
// A tick that closes 500 ms of frame time adds the estimate: up to five divides, the
// lag sweep over ONSET_DEPTH - lag products per lag, and a median pass over the n
// stored tempos.
// Throughput: one request at a time; the next is taken after the result is delivered.
// Reset (synchronous, active low) clears control state, then zeroes every entry of the
// onset history while the input channel is stalled.
`timescale 1ns / 1ps
`default_nettype none
module tempo_autocorr_beat_tracker #(
    parameter int ONSET_DEPTH = tabt_pkg::ONSET_DEPTH_DEF,
    parameter int TEMPO_DEPTH = tabt_pkg::TEMPO_DEPTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    input  wire tabt_pkg::t_in_req               i_in_req,
    output logic                                 o_in_stall,
    output logic                                 o_out_valid,
    output tabt_pkg::t_out_req                   o_out_req,
    input  wire logic                            i_out_stall,
    input  wire logic                            i_cfg_we,
    input  wire logic [tabt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [tabt_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tabt_pkg::*;

    localparam int LAG_W  = $clog2(ONSET_DEPTH);
    localparam int TCW    = $clog2(TEMPO_DEPTH + 1);
    localparam int BASE_W = 15 + TCW;
    localparam logic [LAG_W-1:0] HALF_M1 = LAG_W'(ONSET_DEPTH / 2 - 1);

    // sequencer codes
    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_LO    = 4'd2;
    localparam logic [3:0] S_HI    = 4'd3;
    localparam logic [3:0] S_CORR  = 4'd4;
    localparam logic [3:0] S_BPM   = 4'd5;
    localparam logic [3:0] S_TEMPO = 4'd6;
    localparam logic [3:0] S_PER   = 4'd7;
    localparam logic [3:0] S_CONF  = 4'd8;
    localparam logic [3:0] S_BEAT  = 4'd9;
    localparam logic [3:0] S_PHASE = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    // configuration
    logic [12:0] r_hop;
    logic [17:0] r_sr;
    logic [8:0]  r_mint, r_maxt;

    // tracker state
    logic [3:0]       r_state;
    logic             r_wait;
    logic [15:0]      r_tempo, r_conf, r_bpm, r_phase;
    logic [31:0]      r_per, r_btimer, r_t;
    logic [20:0]      r_etimer;
    logic [1:0]       r_bar;
    logic             r_beat, r_barf, r_det;
    logic [19:0]      r_dt;
    logic [LAG_W-1:0] r_lo, r_hi, r_lag;
    logic [TCW-1:0]   r_n;
    logic [DEN_W-1:0] r_ss;

    // derived operands
    logic [12:0]        w_hop;
    logic [8:0]         w_mint, w_maxt;
    logic [23:0]        w_sr60;
    logic [27:0]        w_sr960;
    logic [21:0]        w_hop_max, w_hop_min;
    logic [LAG_W+12:0]  w_lag_hop;
    logic [BASE_W-1:0]  w_base;
    logic [DEN_W-1:0]   w_cden;
    logic [NUM_W-1:0]   w_div_num;
    logic [DEN_W-1:0]   w_div_den;
    logic               w_div_need, w_div_go, w_div_done;
    logic [NUM_W-1:0]   w_q;
    logic [LAG_W-1:0]   w_hi_c;
    logic               w_accept;
    logic [20:0]        w_esum;
    logic [32:0]        w_tsum;
    logic [31:0]        w_t;
    logic [35:0]        w_t10, w_p7, w_p3;
    logic               w_snap, w_pred;
    logic               w_corr_go, w_corr_done, w_clearing;
    logic [LAG_W-1:0]   w_win_lag;
    logic               w_tmp_go, w_tmp_done;
    logic [15:0]        w_median;
    logic [DEN_W-1:0]   w_ss;
    logic [TCW-1:0]     w_count;

    assign w_hop  = (r_hop == '0) ? 13'd1 : r_hop;
    assign w_mint = (r_mint == '0) ? 9'd1 : r_mint;
    assign w_maxt = (r_maxt == '0) ? 9'd1 : r_maxt;

    assign w_sr60    = 24'(r_sr) * 24'd60;
    assign w_sr960   = 28'(r_sr) * 28'd960;
    assign w_hop_max = 22'(w_maxt) * 22'(w_hop);
    assign w_hop_min = 22'(w_mint) * 22'(w_hop);
    assign w_lag_hop = (LAG_W+13)'(r_lag) * (LAG_W+13)'(w_hop);
    assign w_base    = BASE_W'(r_n) * BASE_W'(25600);
    assign w_cden    = DEN_W'(w_base) + r_ss;

    // one shared divider; the BPM, period and confidence quotients round by adding half the divisor up front
    always_comb begin
        w_div_num  = '0;
        w_div_den  = '0;
        w_div_need = 1'b0;
        unique case (r_state)
            S_LO: begin
                w_div_num  = NUM_W'(w_sr60);
                w_div_den  = DEN_W'(w_hop_max);
                w_div_need = 1'b1;
            end
            S_HI: begin
                w_div_num  = NUM_W'(w_sr60);
                w_div_den  = DEN_W'(w_hop_min);
                w_div_need = 1'b1;
            end
            S_BPM: begin
                w_div_num  = NUM_W'(w_sr960) + NUM_W'(w_lag_hop >> 1);
                w_div_den  = DEN_W'(w_lag_hop);
                w_div_need = 1'b1;
            end
            S_PER: begin
                w_div_num  = NUM_W'(PERIOD_NUM) + NUM_W'(r_tempo >> 1);
                w_div_den  = DEN_W'(r_tempo);
                w_div_need = r_tempo != '0;
            end
            S_CONF: begin
                w_div_num  = (NUM_W'(w_base) << 16) + NUM_W'(w_cden >> 1);
                w_div_den  = w_cden;
                w_div_need = 1'b1;
            end
            S_PHASE: begin
                w_div_num  = NUM_W'({r_t, 16'h0000});
                w_div_den  = DEN_W'(r_per);
                w_div_need = (r_per != '0) && (r_t < r_per);
            end
            default: begin
                w_div_need = 1'b0;
            end
        endcase
    end

    assign w_div_go  = w_div_need && !r_wait;
    assign w_corr_go = (r_state == S_CORR) && !r_wait;
    assign w_tmp_go  = (r_state == S_TEMPO) && !r_wait;

    assign w_hi_c = (w_q > NUM_W'(HALF_M1)) ? HALF_M1 : w_q[LAG_W-1:0];

    assign w_accept = i_in_valid && !o_in_stall;
    assign w_esum   = r_etimer + 21'(i_in_req.dt_us);

    // beat timer advance, saturating, the snap window test and the beat prediction test
    assign w_tsum = {1'b0, r_btimer} + 33'(r_dt);
    assign w_t    = w_tsum[32] ? 32'hFFFF_FFFF : w_tsum[31:0];
    assign w_t10  = 36'(w_t) * 36'd10;
    assign w_p7   = 36'(r_per) * 36'd7;
    assign w_p3   = 36'(r_per) * 36'd3;
    assign w_snap = r_det && (w_t10 > w_p7 || w_t10 < w_p3);
    assign w_pred = w_t >= r_per;

    tabt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_div_go),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_q)
    );

    tabt_corr #(
        .ONSET_DEPTH (ONSET_DEPTH)
    ) u_corr (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (w_accept && !i_in_req.kind),
        .i_wdata    (i_in_req.onset_value),
        .i_go       (w_corr_go),
        .i_lo       (r_lo),
        .i_hi       (r_hi),
        .o_clearing (w_clearing),
        .o_done     (w_corr_done),
        .o_win_lag  (w_win_lag)
    );

    tabt_tempo #(
        .TEMPO_DEPTH (TEMPO_DEPTH)
    ) u_tempo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (w_tmp_go),
        .i_bpm    (r_bpm),
        .o_done   (w_tmp_done),
        .o_median (w_median),
        .o_ss     (w_ss),
        .o_count  (w_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hop    <= HOP_RST;
            r_sr     <= SR_RST;
            r_mint   <= MINT_RST;
            r_maxt   <= MAXT_RST;
            r_state  <= S_CLR;
            r_wait   <= 1'b0;
            r_tempo  <= '0;
            r_conf   <= '0;
            r_bpm    <= '0;
            r_phase  <= '0;
            r_per    <= '0;
            r_btimer <= '0;
            r_t      <= '0;
            r_etimer <= '0;
            r_bar    <= '0;
            r_beat   <= 1'b0;
            r_barf   <= 1'b0;
            r_det    <= 1'b0;
            r_dt     <= '0;
            r_lo     <= '0;
            r_hi     <= '0;
            r_lag    <= '0;
            r_n      <= '0;
            r_ss     <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_HOP_SIZE:    r_hop  <= i_cfg_data[12:0];
                    CFG_SAMPLE_RATE: r_sr   <= i_cfg_data;
                    CFG_MIN_TEMPO:   r_mint <= i_cfg_data[8:0];
                    CFG_MAX_TEMPO:   r_maxt <= i_cfg_data[8:0];
                    default: ;
                endcase
            end
            if (w_div_go || w_corr_go || w_tmp_go) begin
                r_wait <= 1'b1;
            end
            unique case (r_state)
                S_CLR: begin
                    if (!w_clearing) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_dt   <= i_in_req.dt_us;
                        r_det  <= i_in_req.detected;
                        r_beat <= 1'b0;
                        r_barf <= 1'b0;
                        if (!i_in_req.kind) begin
                            // sample push: report phase of the untouched timer
                            r_t     <= r_btimer;
                            r_state <= S_PHASE;
                        end else if (w_esum >= EST_PERIOD_US) begin
                            r_etimer <= '0;
                            r_state  <= S_LO;
                        end else begin
                            r_etimer <= w_esum;
                            r_state  <= S_BEAT;
                        end
                    end
                end
                S_LO: begin
                    if (w_div_done) begin
                        r_wait <= 1'b0;
                        if (w_q > NUM_W'(HALF_M1)) begin
                            r_state <= S_BEAT;      // lag range empty
                        end else begin
                            r_lo    <= (w_q == '0) ? LAG_W'(1) : w_q[LAG_W-1:0];
                            r_state <= S_HI;
                        end
                    end
                end
                S_HI: begin
                    if (w_div_done) begin
                        r_wait <= 1'b0;
                        r_hi   <= w_hi_c;
                        r_state <= (r_lo > w_hi_c) ? S_BEAT : S_CORR;
                    end
                end
                S_CORR: begin
                    if (w_corr_done) begin
                        r_wait  <= 1'b0;
                        r_lag   <= w_win_lag;
                        // zero lag means no positive correlation
                        r_state <= (w_win_lag == '0) ? S_BEAT : S_BPM;
                    end
                end
                S_BPM: begin
                    if (w_div_done) begin
                        r_wait  <= 1'b0;
                        r_bpm   <= (w_q > NUM_W'(16'hFFFF)) ? 16'hFFFF : w_q[15:0];
                        r_state <= S_TEMPO;
                    end
                end
                S_TEMPO: begin
                    if (w_tmp_done) begin
                        r_wait  <= 1'b0;
                        r_tempo <= w_median;
                        r_ss    <= w_ss;
                        r_n     <= w_count;
                        r_state <= S_PER;
                    end
                end
                S_PER: begin
                    if (r_tempo == '0) begin
                        r_per   <= '0;
                        r_state <= (r_n >= TCW'(CONF_MIN_N)) ? S_CONF : S_BEAT;
                    end else if (w_div_done) begin
                        r_wait  <= 1'b0;
                        r_per   <= w_q[31:0];
                        r_state <= (r_n >= TCW'(CONF_MIN_N)) ? S_CONF : S_BEAT;
                    end
                end
                S_CONF: begin
                    if (w_div_done) begin
                        r_wait  <= 1'b0;
                        r_conf  <= (w_q > NUM_W'(16'hFFFF)) ? 16'hFFFF : w_q[15:0];
                        r_state <= S_BEAT;
                    end
                end
                S_BEAT: begin
                    if (r_per != '0) begin
                        r_t <= w_t;
                        if (w_snap) begin
                            r_btimer <= '0;
                        end else if (w_pred) begin
                            r_btimer <= w_t - r_per;
                        end else begin
                            r_btimer <= w_t;
                        end
                        if (w_snap || w_pred) begin
                            r_beat <= 1'b1;
                            r_bar  <= r_bar + 1'b1;
                            r_barf <= r_bar == 2'd3;
                        end
                    end
                    r_state <= S_PHASE;
                end
                S_PHASE: begin
                    if (r_per == '0) begin
                        r_phase <= '0;
                        r_state <= S_OUT;
                    end else if (r_t >= r_per) begin
                        r_phase <= 16'hFFFF;
                        r_state <= S_OUT;
                    end else if (w_div_done) begin
                        r_wait  <= 1'b0;
                        r_phase <= w_q[15:0];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!i_out_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_state == S_OUT;

    always_comb begin
        o_out_req.beat_hit   = r_beat;
        o_out_req.bar_hit    = r_barf;
        o_out_req.phase_frac = r_phase;
        o_out_req.tempo      = r_tempo;
        o_out_req.confidence = r_conf;
    end

    // checks
    a_idle_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !o_out_valid)
        else $error("input open while a result is pending");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second request taken before the first finished");

    a_bar_is_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_out_req.bar_hit || o_out_req.beat_hit))
        else $error("bar flag without beat");

    a_no_tempo_no_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_per == '0) |-> (!o_out_req.beat_hit && o_out_req.phase_frac == '0))
        else $error("beat output without a beat period");

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import tabt_pkg::*;

    // request kinds
    localparam bit KIND_ONSET = 1'b0;
    localparam bit KIND_TICK  = 1'b1;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    t_in_req               i_in_req;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out_req              o_out_req;
    logic                  i_out_stall;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    tempo_autocorr_beat_tracker i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_req    (i_in_req),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_req   (o_out_req),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // ---------------------------------------------------------------
    // Tracker model state (mirrors what the block keeps)
    // ---------------------------------------------------------------
    longint unsigned hop_r, rate_r, tmin_r, tmax_r;
    bit [15:0]       onset_ring[256];
    int unsigned     onset_wr;
    bit [15:0]       bpm_ring[8];
    int unsigned     bpm_wr, bpm_cnt;
    bit [15:0]       tempo_cur, conf_cur;
    longint unsigned period_us, beat_us, est_us;
    bit [1:0]        bar_pos;

    t_out_req tracker_results[$];   // results still owed by the block
    int       err_cnt;
    int       mism_cnt;
    bit       quiet;                // no idling on either side

    function automatic longint unsigned at_least_one(longint unsigned v);
        return (v == 0) ? 1 : v;
    endfunction

    // Autocorrelation sweep, median of recent BPMs, and confidence.
    function automatic void update_tempo();
        longint unsigned hop, scaled, lo, hi, best, acc, bpm, ss, base, c;
        int unsigned     win_lag, n, lag, i;
        bit [15:0]       srt[8];
        bit [15:0]       key;
        int              j;
        longint          d;
        hop    = at_least_one(hop_r);
        scaled = 60 * rate_r;
        lo     = scaled / (at_least_one(tmax_r) * hop);
        hi     = scaled / (at_least_one(tmin_r) * hop);
        best   = 0;
        win_lag = 0;
        if (lo < 1) lo = 1;
        if (hi >= 128) hi = 127;
        for (lag = 32'(lo); lag <= hi; lag++) begin
            acc = 0;
            for (i = 0; i < 256 - lag; i++)
                acc += longint'(onset_ring[(onset_wr + i) % 256]) *
                       longint'(onset_ring[(onset_wr + i + lag) % 256]);
            // first strictly best lag wins
            if (acc > best) begin
                best = acc;
                win_lag = lag;
            end
        end
        if (win_lag == 0 || best == 0) return;
        bpm = (960 * rate_r + (64'(win_lag) * hop) / 2) / (64'(win_lag) * hop);
        if (bpm > 65535) bpm = 65535;
        bpm_ring[bpm_wr] = bpm[15:0];
        bpm_wr = (bpm_wr + 1) % 8;
        if (bpm_cnt < 8) bpm_cnt++;
        n = bpm_cnt;
        for (i = 0; i < n; i++) srt[i] = bpm_ring[i];
        for (i = 1; i < n; i++) begin
            key = srt[i];
            j = i;
            while (j > 0 && srt[j-1] > key) begin
                srt[j] = srt[j-1];
                j--;
            end
            srt[j] = key;
        end
        tempo_cur = srt[n/2];
        period_us = (tempo_cur != 0) ?
                    (64'd960000000 + tempo_cur / 2) / tempo_cur : 0;
        if (n >= 4) begin
            ss = 0;
            base = 25600 * n;
            for (i = 0; i < n; i++) begin
                d = longint'(bpm_ring[i]) - longint'(tempo_cur);
                ss += d * d;
            end
            c = (65536 * base + (base + ss) / 2) / (base + ss);
            if (c > 65535) c = 65535;
            conf_cur = c[15:0];
        end
    endfunction

    function automatic bit [15:0] beat_fraction();
        longint unsigned p;
        if (period_us == 0) return 16'd0;
        p = (beat_us << 16) / period_us;
        return (p > 65535) ? 16'hFFFF : p[15:0];
    endfunction

    function automatic t_out_req track_request(t_in_req r);
        t_out_req        o;
        longint unsigned t;
        bit              predicted;
        o = '0;
        if (r.kind == KIND_ONSET) begin
            onset_ring[onset_wr] = r.onset_value;
            onset_wr = (onset_wr + 1) % 256;
            o.phase_frac = beat_fraction();
        end else begin
            est_us += r.dt_us;
            if (est_us >= 500000) begin
                update_tempo();
                est_us = 0;
            end
            if (period_us != 0) begin
                t = beat_us + r.dt_us;
                if (t > 64'hFFFFFFFF) t = 64'hFFFFFFFF;
                beat_us = t;
                o.phase_frac = beat_fraction();
                predicted = (t >= period_us);
                // onset near a beat boundary snaps the timer
                if (r.detected && (10 * t > 7 * period_us || 10 * t < 3 * period_us)) begin
                    beat_us = 0;
                    o.beat_hit = 1'b1;
                end else if (predicted) begin
                    beat_us -= period_us;
                    o.beat_hit = 1'b1;
                end
                if (o.beat_hit) begin
                    bar_pos++;
                    o.bar_hit = (bar_pos == 2'd0);
                end
            end
        end
        o.tempo      = tempo_cur;
        o.confidence = conf_cur;
        return o;
    endfunction

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------
    // write enable stays high across back to back writes; caller drops it
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_HOP_SIZE:    hop_r  = val & 18'h1FFF;
            CFG_SAMPLE_RATE: rate_r = val;
            CFG_MIN_TEMPO:   tmin_r = val & 18'h1FF;
            CFG_MAX_TEMPO:   tmax_r = val & 18'h1FF;
            default: ;
        endcase
    endtask

    // Wait until the block has drained, then program a full setting.
    task automatic set_config(int hop, int rate, int tmin, int tmax);
        i_in_valid <= 1'b0;
        while (tracker_results.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        write_reg(CFG_HOP_SIZE, CFG_DATA_W'(hop));
        write_reg(CFG_SAMPLE_RATE, CFG_DATA_W'(rate));
        write_reg(CFG_MIN_TEMPO, CFG_DATA_W'(tmin));
        write_reg(CFG_MAX_TEMPO, CFG_DATA_W'(tmax));
        i_cfg_we <= 1'b0;
    endtask

    // Present one request, hold it until accepted, then maybe idle.
    task automatic send_request(t_in_req r, bit typed, t_out_req typed_res);
        t_out_req pred;
        i_in_valid <= 1'b1;
        i_in_req   <= r;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pred = track_request(r);
        tracker_results.push_back(typed ? typed_res : pred);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
    endtask

    function automatic t_in_req onset_req(bit [15:0] v);
        t_in_req r;
        r = '0;
        r.kind = KIND_ONSET;
        r.onset_value = v;
        return r;
    endfunction

    function automatic t_in_req tick_req(bit [19:0] dt, bit det);
        t_in_req r;
        r = '0;
        r.kind = KIND_TICK;
        r.dt_us = dt;
        r.detected = det;
        return r;
    endfunction

    // Pulse trains with a period inside the searched lag range, ticks
    // woven in so estimates fire, plus some fully random requests.
    task automatic random_phase(int count, int per_lo, int per_hi);
        int      sent, per, k;
        t_in_req r;
        sent = 0;
        while (sent < count) begin
            per = $urandom_range(per_lo, per_hi);
            for (k = 0; k < 3 * per && sent < count; k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    r = t_in_req'($bits(t_in_req)'({$urandom, $urandom}));
                    if (r.dt_us > 20'd1000000) r.dt_us = 20'($urandom_range(0, 1000000));
                end else if (k % 2 == 1) begin
                    r = tick_req(20'($urandom_range(10000, 120000)),
                                 $urandom_range(0, 2) == 0);
                end else begin
                    r = onset_req((k % per < 2) ? 16'($urandom_range(16'h4000, 16'hFFFF))
                                                : 16'($urandom_range(0, 16'h0040)));
                end
                send_request(r, 1'b0, '0);
                sent++;
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Directed table: typed results only where no tempo exists yet
    // ---------------------------------------------------------------
    typedef struct {
        t_in_req  req;
        bit       typed;
        t_out_req res;
    } t_row;

    t_row rows[$];

    task automatic add_row(t_in_req r, bit typed);
        t_row row;
        row.req = r;
        row.typed = typed;
        row.res = '0;
        rows.push_back(row);
    endtask

    // ---------------------------------------------------------------
    // Receive side: random stall bursts, in-order compare
    // ---------------------------------------------------------------
    int stall_left;

    always @(posedge i_clk) begin
        logic nxt;
        if (!i_rst_n || quiet) begin
            nxt = 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left--;
            nxt = 1'b1;
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 16);
            nxt = 1'b1;
        end else begin
            nxt = 1'b0;
        end
        i_out_stall <= nxt;
    end

    always @(posedge i_clk) begin
        t_out_req exp_res;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (tracker_results.size() == 0) begin
                err_cnt++;
                if (mism_cnt++ < 10)
                    $display("unexpected result %h", o_out_req);
            end else begin
                exp_res = tracker_results.pop_front();
                if (o_out_req.beat_hit   !== exp_res.beat_hit   ||
                    o_out_req.bar_hit    !== exp_res.bar_hit    ||
                    o_out_req.phase_frac !== exp_res.phase_frac ||
                    o_out_req.tempo      !== exp_res.tempo      ||
                    o_out_req.confidence !== exp_res.confidence) begin
                    err_cnt++;
                    if (mism_cnt++ < 10)
                        $display("mismatch: exp beat %b bar %b ph %h tempo %h conf %h / got beat %b bar %b ph %h tempo %h conf %h",
                                 exp_res.beat_hit, exp_res.bar_hit, exp_res.phase_frac,
                                 exp_res.tempo, exp_res.confidence,
                                 o_out_req.beat_hit, o_out_req.bar_hit,
                                 o_out_req.phase_frac, o_out_req.tempo, o_out_req.confidence);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_req    = '0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_data  = '0;
        quiet = 1'b0;
        hop_r = 512;
        rate_r = 44100;
        tmin_r = 60;
        tmax_r = 200;
        foreach (onset_ring[k]) onset_ring[k] = '0;
        foreach (bpm_ring[k]) bpm_ring[k] = '0;
        onset_wr = 0;
        bpm_wr = 0;
        bpm_cnt = 0;
        tempo_cur = 0;
        conf_cur = 0;
        period_us = 0;
        beat_us = 0;
        est_us = 0;
        bar_pos = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // no tempo yet: flags and phase stay zero, whatever comes in
        add_row(tick_req(20'd0, 1'b0), 1'b1);
        add_row(tick_req(20'd0, 1'b1), 1'b1);
        add_row(onset_req(16'hFFFF), 1'b1);
        add_row(onset_req(16'h0000), 1'b1);
        add_row(onset_req(16'hFFFF), 1'b1);
        add_row(tick_req(20'd499999, 1'b1), 1'b1);
        // closes 500 ms but adjacent samples do not correlate at lag 25+
        add_row(tick_req(20'd1, 1'b0), 1'b1);
        add_row(tick_req(20'd1000000, 1'b1), 1'b1);
        add_row(tick_req(20'hAAAAA, 1'b0), 1'b0);
        add_row(tick_req(20'h55555, 1'b1), 1'b0);
        add_row(onset_req(16'h5555), 1'b0);
        add_row(onset_req(16'hAAAA), 1'b0);
        foreach (rows[k]) send_request(rows[k].req, rows[k].typed, rows[k].res);

        // default setting, lags 25..86
        random_phase(15, 25, 86);

        // short lags: hop 4096, lags 3..10
        set_config(4096, 44100, 60, 200);
        random_phase(30, 3, 10);

        // let everything drain once before going on
        i_in_valid <= 1'b0;
        while (tracker_results.size() != 0) @(posedge i_clk);
        random_phase(15, 3, 10);

        // empty lag range: no estimate can be made
        set_config(1, 192000, 400, 400);
        random_phase(8, 3, 10);

        // widest tempo window, lowest rate: lags 1..5
        set_config(4096, 8000, 20, 400);
        random_phase(10, 1, 5);
        quiet = 1'b1;
        random_phase(10, 1, 5);

        i_in_valid <= 1'b0;
        while (tracker_results.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (err_cnt == 0 && tracker_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #200_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
